// ----- rtl/core/llrc_pkg.sv -----
// shared types, request codes and result codes for the lossy lock reference cache
package llrc_pkg;

    localparam int CACHE_SLOTS_DEF = 15;

    // request codes
    localparam logic [1:0] OP_REMEMBER = 2'd0;
    localparam logic [1:0] OP_FORGET   = 2'd1;
    localparam logic [1:0] OP_LIST     = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_OWNED   = 3'd1;
    localparam logic [2:0] ST_IGNORED     = 3'd2;
    localparam logic [2:0] ST_LISTED      = 3'd3;
    localparam logic [2:0] ST_UNAVAILABLE = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       rem_do;
        logic       fgt_do;
        logic       ovf_set;
        logic       ptr_top;
        logic       ptr_clr;
        logic       ptr_dec;
        logic       ptr_inc;
        logic       emit;
        logic [2:0] emit_status;
        logic       emit_entry;
        logic       emit_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       ovf;
        logic       fill_zero;
        logic       full;
        logic       match;
        logic       ptr_zero;
        logic       ptr_top;
    } t_stat;

endpackage

// ----- rtl/core/llrc_ctrl.sv -----
// request sequencer for the lossy lock reference cache
module llrc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  llrc_pkg::t_stat i_stat,
    output llrc_pkg::t_cmd  o_cmd
);
    import llrc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_FRD  = 6'b000100,
        S_FCMP = 6'b001000,
        S_LRD  = 6'b010000,
        S_LOUT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_last = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                priority case (i_stat.op)
                    OP_REMEMBER: begin
                        o_cmd.emit = 1'b1;
                        if (i_stat.ovf) begin
                            o_cmd.emit_status = ST_IGNORED;
                        end else if (!i_stat.full) begin
                            o_cmd.rem_do      = 1'b1;
                            o_cmd.emit_status = ST_OK;
                        end else begin
                            o_cmd.ovf_set     = 1'b1;
                            o_cmd.emit_status = ST_IGNORED;
                        end
                    end
                    OP_FORGET: begin
                        if (i_stat.ovf) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_IGNORED;
                        end else if (i_stat.fill_zero) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_NOT_OWNED;
                        end else begin
                            // search starts at the newest entry
                            o_cmd.ptr_top = 1'b1;
                            n_state       = S_FRD;
                        end
                    end
                    OP_LIST: begin
                        if (i_stat.ovf || i_stat.fill_zero) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_UNAVAILABLE;
                        end else begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = S_LRD;
                        end
                    end
                    default: begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_IGNORED;
                    end
                endcase
            end
            S_FRD: begin
                n_state = S_FCMP;
            end
            S_FCMP: begin
                if (i_stat.match) begin
                    o_cmd.fgt_do      = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    n_state           = S_IDLE;
                end else if (i_stat.ptr_zero) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_NOT_OWNED;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.ptr_dec = 1'b1;
                    n_state       = S_FRD;
                end
            end
            S_LRD: begin
                n_state = S_LOUT;
            end
            S_LOUT: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = ST_LISTED;
                o_cmd.emit_entry  = 1'b1;
                o_cmd.emit_last   = i_stat.ptr_top;
                if (i_stat.ptr_top) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_LRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- rtl/core/llrc_dp.sv -----
// slot memory, fill count, overflow flag and result register of the lock reference cache
module llrc_dp #(
    parameter int CACHE_SLOTS = llrc_pkg::CACHE_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_op,
    input  logic [63:0]     i_lock_ref,
    input  llrc_pkg::t_cmd  i_cmd,
    output llrc_pkg::t_stat o_stat,
    output logic            o_valid,
    output logic [2:0]      o_status,
    output logic [63:0]     o_entry,
    output logic [3:0]      o_held_count,
    output logic            o_overflowed,
    output logic            o_last
);
    import llrc_pkg::*;

    localparam int FW = $clog2(CACHE_SLOTS + 1);
    localparam int PW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam logic [FW-1:0] FILL_MAX = FW'(CACHE_SLOTS);

    logic [63:0]   r_mem [CACHE_SLOTS];
    logic [63:0]   r_rd_data;
    logic [63:0]   r_ref;
    logic [63:0]   r_last_val;
    logic [1:0]    r_op;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] top_idx;
    logic          ptr_is_top;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic [FW-1:0] held;
    logic [FW+3:0] held_ext;

    logic          r_out_valid;
    logic [2:0]    r_status;
    logic [63:0]   r_entry;
    logic [3:0]    r_held;
    logic          r_ovf_out;
    logic          r_last;

    assign top_idx    = PW'(r_fill - FW'(1));
    assign ptr_is_top = (r_ptr == top_idx);

    always_comb begin
        n_fill  = r_fill;
        n_ovf   = r_ovf;
        n_ptr   = r_ptr;
        wr_en   = 1'b0;
        wr_addr = r_fill[PW-1:0];
        wr_data = r_ref;
        if (i_cmd.rem_do) begin
            wr_en   = 1'b1;
            wr_addr = r_fill[PW-1:0];
            n_fill  = r_fill + FW'(1);
        end
        if (i_cmd.fgt_do) begin
            // newest entry fills the hole
            wr_en   = 1'b1;
            wr_addr = r_ptr;
            wr_data = ptr_is_top ? r_rd_data : r_last_val;
            n_fill  = r_fill - FW'(1);
        end
        if (i_cmd.ovf_set) begin
            n_ovf = 1'b1;
        end
        priority if (i_cmd.ptr_top) begin
            n_ptr = top_idx;
        end else if (i_cmd.ptr_clr) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_dec) begin
            n_ptr = r_ptr - PW'(1);
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_op;
            r_ref <= i_lock_ref;
        end
        // first compare sees the newest entry, keep it for the move
        if (i_cmd.ptr_dec && ptr_is_top) begin
            r_last_val <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_ptr       <= n_ptr;
            r_out_valid <= i_cmd.emit;
        end
    end

    assign held     = n_ovf ? '0 : n_fill;
    assign held_ext = {4'b0000, held};

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status  <= i_cmd.emit_status;
            r_entry   <= i_cmd.emit_entry ? r_rd_data : 64'd0;
            r_held    <= held_ext[3:0];
            r_ovf_out <= n_ovf;
            r_last    <= i_cmd.emit_last;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.ovf       = r_ovf;
    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.full      = (r_fill == FILL_MAX);
    assign o_stat.match     = (r_rd_data == r_ref);
    assign o_stat.ptr_zero  = (r_ptr == '0);
    assign o_stat.ptr_top   = ptr_is_top;

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_entry      = r_entry;
    assign o_held_count = r_held;
    assign o_overflowed = r_ovf_out;
    assign o_last       = r_last;

endmodule

// ----- rtl/core/lossy_lock_reference_cache.sv -----
// top level of the lossy lock reference cache
// A request is taken when start is high and busy is low; busy stays high until its
// last result has been issued, and each result appears on the o_ ports for one cycle
// with o_valid high, in the cycle after it is decided, with no way to hold it off.
// Handles live in a slot memory with a registered read, so every slot visit passes
// through a read state and then a compare or output state: remember and any request
// that needs no search are decided in the execute state, a forget compares slots
// from the newest down (at most the fill count) to a match or the oldest slot, and a list
// issues one result per slot visit for its n entries. After reset it is ready at once.
module lossy_lock_reference_cache #(
    parameter int CACHE_SLOTS = llrc_pkg::CACHE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_lock_ref,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_entry,
    output logic [3:0]  o_held_count,
    output logic        o_overflowed,
    output logic        o_last
);
    import llrc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    llrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    llrc_dp #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .i_lock_ref   (i_lock_ref),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_entry      (o_entry),
        .o_held_count (o_held_count),
        .o_overflowed (o_overflowed),
        .o_last       (o_last)
    );

`ifndef SYNTH
    // nothing is tracked once overflowed
    a_ovf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |-> o_held_count == 4'd0)
        else $error("overflowed result reports held handles");

    // a taken request keeps the block busy for its decision cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken without going busy");

    // the final result frees the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("busy after final result");

    // a list still in progress keeps the block busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy && o_status == ST_LISTED)
        else $error("non-final result outside a list");
`endif

endmodule
